[design/ccxm_pkg.sv]
// ----------------------------------------------------------------------------
// ccxm_pkg: shared types and functions for the XOR mixing cube
// Cube geometry, item and axis codes, and the combinational round functions.
// ----------------------------------------------------------------------------
package ccxm_pkg;

    localparam int CUBE_SIDE  = 4;
    localparam int COORD_BITS = $clog2(CUBE_SIDE);
    localparam int CUBE_BITS  = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
    localparam int LINE_BITS  = 2 * COORD_BITS;
    localparam int ROUND_BITS = 16;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ROUND = 1'b1;

    typedef logic [CUBE_BITS-1:0]  t_cube;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [LINE_BITS-1:0]  t_line;

    // Axis pair used by the neighbour rule, chosen by the round index mod 3.
    typedef enum logic [1:0] {
        AXES_IJ = 2'd0,
        AXES_IK = 2'd1,
        AXES_KJ = 2'd2
    } t_axis_pair;

    // Axis along which a swapped line runs.
    typedef enum logic [1:0] {
        AXIS_I = 2'd0,
        AXIS_J = 2'd1,
        AXIS_K = 2'd2
    } t_axis;

    // Bit position of cell (i, j, k).
    function automatic logic [LINE_BITS+COORD_BITS-1:0] cell_pos(
        input t_coord ci, input t_coord cj, input t_coord ck);
        return {ci, cj, ck};
    endfunction

    // Round index mod 3: powers of four are all 1 mod 3, so the base-4 digit
    // sum keeps the residue. Two further digit sums bring it below 5.
    function automatic t_axis_pair round_mod3(input logic [ROUND_BITS-1:0] r);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int d = 0; d < ROUND_BITS / 2; d++) begin
            s1 = s1 + {3'b000, r[2*d +: 2]};
        end
        s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]} + {2'b00, s1[4]};
        s3 = {1'b0, s2[1:0]} + {2'b00, s2[2]};
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return t_axis_pair'(s3[1:0]);
    endfunction

    // Every cell becomes the XOR of its four wrap-around neighbours on the
    // chosen pair of axes, plus itself unless skip_self is set.
    function automatic t_cube neighbour_rule(
        input t_cube cube, input t_axis_pair pair, input logic skip_self);
        t_cube  res;
        t_coord ci;
        t_coord cj;
        t_coord ck;
        logic   acc;
        res = '0;
        for (int ii = 0; ii < CUBE_SIDE; ii++) begin
            for (int jj = 0; jj < CUBE_SIDE; jj++) begin
                for (int kk = 0; kk < CUBE_SIDE; kk++) begin
                    ci  = COORD_BITS'(ii);
                    cj  = COORD_BITS'(jj);
                    ck  = COORD_BITS'(kk);
                    acc = skip_self ? 1'b0 : cube[cell_pos(ci, cj, ck)];
                    unique case (pair)
                        AXES_IJ: begin
                            acc = acc ^ cube[cell_pos(ci + 1'b1, cj, ck)]
                                      ^ cube[cell_pos(ci - 1'b1, cj, ck)]
                                      ^ cube[cell_pos(ci, cj + 1'b1, ck)]
                                      ^ cube[cell_pos(ci, cj - 1'b1, ck)];
                        end
                        AXES_IK: begin
                            acc = acc ^ cube[cell_pos(ci + 1'b1, cj, ck)]
                                      ^ cube[cell_pos(ci - 1'b1, cj, ck)]
                                      ^ cube[cell_pos(ci, cj, ck + 1'b1)]
                                      ^ cube[cell_pos(ci, cj, ck - 1'b1)];
                        end
                        AXES_KJ: begin
                            acc = acc ^ cube[cell_pos(ci, cj, ck + 1'b1)]
                                      ^ cube[cell_pos(ci, cj, ck - 1'b1)]
                                      ^ cube[cell_pos(ci, cj + 1'b1, ck)]
                                      ^ cube[cell_pos(ci, cj - 1'b1, ck)];
                        end
                        default: begin
                            acc = 1'b0;
                        end
                    endcase
                    res[cell_pos(ci, cj, ck)] = acc;
                end
            end
        end
        return res;
    endfunction

    // Swap lines la and lb running along axis run. A line number gives the
    // two fixed coordinates as its low and high digit. With la equal to lb
    // every cell maps to itself, so the cube is left alone.
    function automatic t_cube swap_lines(
        input t_cube cube, input t_axis run, input t_line la, input t_line lb);
        t_cube  res;
        t_coord ci;
        t_coord cj;
        t_coord ck;
        t_line  own;
        t_line  src;
        t_coord si;
        t_coord sj;
        t_coord sk;
        res = '0;
        for (int ii = 0; ii < CUBE_SIDE; ii++) begin
            for (int jj = 0; jj < CUBE_SIDE; jj++) begin
                for (int kk = 0; kk < CUBE_SIDE; kk++) begin
                    ci = COORD_BITS'(ii);
                    cj = COORD_BITS'(jj);
                    ck = COORD_BITS'(kk);
                    unique case (run)
                        AXIS_J:  own = {ck, ci};
                        AXIS_I:  own = {ck, cj};
                        AXIS_K:  own = {cj, ci};
                        default: own = {ck, ci};
                    endcase
                    if (own == la) begin
                        src = lb;
                    end else if (own == lb) begin
                        src = la;
                    end else begin
                        src = own;
                    end
                    si = ci;
                    sj = cj;
                    sk = ck;
                    unique case (run)
                        AXIS_J: begin
                            si = src[COORD_BITS-1:0];
                            sk = src[LINE_BITS-1:COORD_BITS];
                        end
                        AXIS_I: begin
                            sj = src[COORD_BITS-1:0];
                            sk = src[LINE_BITS-1:COORD_BITS];
                        end
                        AXIS_K: begin
                            si = src[COORD_BITS-1:0];
                            sj = src[LINE_BITS-1:COORD_BITS];
                        end
                        default: begin
                            si = ci;
                        end
                    endcase
                    res[cell_pos(ci, cj, ck)] = cube[cell_pos(si, sj, sk)];
                end
            end
        end
        return res;
    endfunction

endpackage

[design/cube_ca_xor_mix_round.sv]
// ----------------------------------------------------------------------------
// cube_ca_xor_mix_round: 4x4x4 XOR cellular cube with line swaps
// Holds a 64-cell cube and applies load or round items, one item per cycle
// Usage. Items arrive on the input channel (i_in_valid, o_in_stall) and carry
// i_kind, i_cube_in and i_round_index. A load item replaces the cube; a round
// item applies the neighbour XOR rule on the axis pair chosen by the round
// index mod 3, then three line swaps between lines r mod 16 and r*r mod 16.
// Every item yields exactly one result item on the output channel
// (o_out_valid, i_out_stall) carrying the cube after that item.
// From acceptance an item passes through the input register, where the axis
// pair and line numbers are decoded, and then through the round logic into
// the cube register, which also drives the output. Throughput is one item
// per cycle while the receiver does not stall, as the combinational round
// logic feeds back into the cube register.
// The user must write the drop-self register (i_cfg_we, i_cfg_data) only
// while idle; the block does not enforce this. A synchronous reset (i_rst_n
// low) clears the cube, the drop-self register and both valid flags. When
// the receiver stalls, the result holds and one further item can wait in
// the input register; after that o_in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module cube_ca_xor_mix_round
    import ccxm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [CUBE_BITS-1:0]  i_cube_in,
    input  logic [ROUND_BITS-1:0] i_round_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CUBE_BITS-1:0]  o_cube_out
);

    // Configuration.
    logic       r_drop_self;

    // Input register: the item with its round index already decoded.
    logic       r_s1_valid;
    logic       r_s1_kind;
    t_cube      r_s1_cube;
    t_axis_pair r_s1_pair;
    t_line      r_s1_la;
    t_line      r_s1_lb;

    // Cube register; it is also the result register.
    t_cube      r_cube;
    logic       r_out_valid;

    logic       advance;
    logic       in_take;
    logic [2*LINE_BITS-1:0] square;
    t_line      in_la;
    t_cube      mixed;
    t_cube      swap_j;
    t_cube      swap_i;
    t_cube      swap_k;
    t_cube      n_cube;

    // The result register frees up when it is empty or its item is taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Only the low digit of the round index matters for both line numbers.
    assign in_la  = i_round_index[LINE_BITS-1:0];
    assign square = {{LINE_BITS{1'b0}}, in_la} * {{LINE_BITS{1'b0}}, in_la};

    // Round: neighbour rule, then swaps along j, i and k in that order.
    assign mixed  = neighbour_rule(r_cube, r_s1_pair, r_drop_self);
    assign swap_j = swap_lines(mixed, AXIS_J, r_s1_la, r_s1_lb);
    assign swap_i = swap_lines(swap_j, AXIS_I, r_s1_la, r_s1_lb);
    assign swap_k = swap_lines(swap_i, AXIS_K, r_s1_la, r_s1_lb);
    assign n_cube = (r_s1_kind == KIND_LOAD) ? r_s1_cube : swap_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_self <= 1'b0;
        end else if (i_cfg_we) begin
            r_drop_self <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_kind <= i_kind;
            r_s1_cube <= i_cube_in;
            r_s1_pair <= round_mod3(i_round_index);
            r_s1_la   <= in_la;
            r_s1_lb   <= square[LINE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cube      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_cube <= n_cube;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cube_out  = r_cube;

endmodule

[design/ccxm_checker.sv]
// ----------------------------------------------------------------------------
// ccxm_checker: port-level assertions for the XOR mixing cube
// Watches the handshakes and the load path of the top level over time.
// ----------------------------------------------------------------------------
module ccxm_checker
    import ccxm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  i_kind,
    input logic [CUBE_BITS-1:0]  i_cube_in,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [CUBE_BITS-1:0]  o_cube_out
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_cube_out))
        else $error("result payload changed while stalled");

    // The input side only stalls when a result is waiting behind a stall.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Reset leaves no result item on offer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A load item whose path is free comes out of the cube register unchanged.
    a_load_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_LOAD)
        ##1 (!o_out_valid || !i_out_stall)
        |=> o_out_valid && o_cube_out == $past(i_cube_in, 2))
        else $error("loaded cube not returned");

endmodule

bind cube_ca_xor_mix_round ccxm_checker u_ccxm_checker (.*);

[tb/cube_mix_checker.sv]
// ----------------------------------------------------------------------------
// cube_mix_checker: result predictor and comparator for the XOR mixing cube
// Watches the configuration port and both item channels, keeps its own copy
// of the cube and the drop-self register, and compares every result item
// against the oldest predicted cube.
// ----------------------------------------------------------------------------
module cube_mix_checker
    import ccxm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_kind,
    input  logic [CUBE_BITS-1:0]  i_cube_in,
    input  logic [ROUND_BITS-1:0] i_round_index,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [CUBE_BITS-1:0]  i_cube_out,
    output int                    o_mismatch_count,
    output int                    o_pending_count
);

    localparam int SIDE = CUBE_SIDE;

    t_cube cube_state;
    logic  drop_self_copy;
    t_cube expected_cubes[$];
    t_cube want;

    initial begin
        o_mismatch_count = 0;
        o_pending_count  = 0;
    end

    function automatic int cell_index(input int x, input int y, input int z);
        return (x * SIDE + y) * SIDE + z;
    endfunction

    // Each cell takes the XOR of its wrap-around neighbours along two axes,
    // and of itself unless the cell is left out.
    function automatic t_cube neighbour_xor(input t_cube cube, input t_axis ax,
                                            input t_axis bx, input logic skip_self);
        t_cube nxt;
        int    c[3];
        int    d[3];
        int    a;
        logic  acc;
        nxt = '0;
        for (int i = 0; i < SIDE; i++) begin
            for (int j = 0; j < SIDE; j++) begin
                for (int k = 0; k < SIDE; k++) begin
                    c[0] = i;
                    c[1] = j;
                    c[2] = k;
                    acc  = skip_self ? 1'b0 : cube[cell_index(i, j, k)];
                    for (int n = 0; n < 2; n++) begin
                        a = (n == 0) ? int'(ax) : int'(bx);
                        d[0] = c[0];
                        d[1] = c[1];
                        d[2] = c[2];
                        d[a] = (c[a] + 1) % SIDE;
                        acc  = acc ^ cube[cell_index(d[0], d[1], d[2])];
                        d[a] = (c[a] + SIDE - 1) % SIDE;
                        acc  = acc ^ cube[cell_index(d[0], d[1], d[2])];
                    end
                    nxt[cell_index(i, j, k)] = acc;
                end
            end
        end
        return nxt;
    endfunction

    // Exchanges two lines along one axis; a line number holds the first fixed
    // coordinate in its low digit and the second in its high digit.
    function automatic t_cube swap_line_pair(input t_cube cube, input t_axis along,
                                             input t_axis fx, input t_axis fy,
                                             input int l1, input int l2);
        int   c1[3];
        int   c2[3];
        int   p1;
        int   p2;
        logic v1;
        logic v2;
        if (l1 == l2) begin
            return cube;
        end
        for (int t = 0; t < SIDE; t++) begin
            c1[int'(along)] = t;
            c2[int'(along)] = t;
            c1[int'(fx)]    = l1 % SIDE;
            c1[int'(fy)]    = l1 / SIDE;
            c2[int'(fx)]    = l2 % SIDE;
            c2[int'(fy)]    = l2 / SIDE;
            p1 = cell_index(c1[0], c1[1], c1[2]);
            p2 = cell_index(c2[0], c2[1], c2[2]);
            v1 = cube[p1];
            v2 = cube[p2];
            cube[p1] = v2;
            cube[p2] = v1;
        end
        return cube;
    endfunction

    function automatic t_cube cube_after_round(input t_cube cube,
                                               input logic [ROUND_BITS-1:0] r,
                                               input logic skip_self);
        t_axis_pair  pair;
        int unsigned nib;
        int          la;
        int          lb;
        t_cube       c;
        pair = t_axis_pair'(2'(r % 16'd3));
        nib  = r[3:0];
        la   = int'(nib);
        lb   = int'((nib * nib) % 16);
        case (pair)
            AXES_IJ: c = neighbour_xor(cube, AXIS_I, AXIS_J, skip_self);
            AXES_IK: c = neighbour_xor(cube, AXIS_I, AXIS_K, skip_self);
            default: c = neighbour_xor(cube, AXIS_K, AXIS_J, skip_self);
        endcase
        c = swap_line_pair(c, AXIS_J, AXIS_I, AXIS_K, la, lb);
        c = swap_line_pair(c, AXIS_I, AXIS_J, AXIS_K, la, lb);
        c = swap_line_pair(c, AXIS_K, AXIS_I, AXIS_J, la, lb);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input t_cube got, input t_cube exp_cube);
        $display("checker: %s: cube_out %h, predicted %h", what, got, exp_cube);
        o_mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cube_state     = '0;
            drop_self_copy = 1'b0;
            expected_cubes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_cubes.size() == 0) begin
                    report_mismatch("result with no item outstanding", i_cube_out, '0);
                end else begin
                    want = expected_cubes.pop_front();
                    if (i_cube_out !== want) begin
                        report_mismatch("wrong cube", i_cube_out, want);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_LOAD) begin
                    cube_state = i_cube_in;
                end else begin
                    cube_state = cube_after_round(cube_state, i_round_index, drop_self_copy);
                end
                expected_cubes.push_back(cube_state);
            end
            if (i_cfg_we) begin
                drop_self_copy = i_cfg_data;
            end
        end
        o_pending_count = expected_cubes.size();
    end

endmodule

[tb/cube_ca_xor_mix_round_tb.sv]
// ----------------------------------------------------------------------------
// cube_ca_xor_mix_round_tb: self-checking bench for the XOR mixing cube
// Drives load and round items with random gaps and result stalls, switches
// the drop-self register between phases, and lets a checker beside the block
// predict and compare every resulting cube.
// ----------------------------------------------------------------------------
module cube_ca_xor_mix_round_tb;
    import ccxm_pkg::*;

    // Generous ceiling on the run: about 1460 items, each at worst waiting out
    // a gap and a stall of up to MAX_WAIT and the pipeline, stay well within it.
    localparam int CYCLE_LIMIT    = 500000;
    localparam int PHASE_ITEMS    = 240;
    localparam int RANDOM_PHASES  = 6;
    localparam int MAX_WAIT       = 18;
    localparam int DRAIN_CYCLES   = 8;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic                  cfg_data     = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  kind         = KIND_LOAD;
    logic [CUBE_BITS-1:0]  cube_in      = '0;
    logic [ROUND_BITS-1:0] round_index  = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [CUBE_BITS-1:0]  cube_out;

    int mismatch_count;
    int pending_count;
    int cycle_count   = 0;

    // Calm stretches switch idling off on one side for a while, so that
    // back-to-back traffic is exercised as well as gappy traffic.
    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;
    int stall_left    = 0;
    int results_taken = 0;

    // The clock runs with a period of 20 units, starting low.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    cube_ca_xor_mix_round u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (kind),
        .i_cube_in     (cube_in),
        .i_round_index (round_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_cube_out    (cube_out)
    );

    cube_mix_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_cube_in        (cube_in),
        .i_round_index    (round_index),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_cube_out       (cube_out),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // Watchdog: a run that hangs is ended here as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Zero waits are favoured a little so that short gaps turn up often.
    function automatic int draw_wait();
        if ($urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Result side. After every result taken, the receiver draws how many
    // cycles it will hold stall high before it takes the next one. Each branch
    // makes at most one assignment to the stall, so the value is never lowered
    // and raised within one step.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (out_valid && !out_stall) begin
            results_taken++;
            if (results_taken % 90 == 0) begin
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
            stall_left = receiver_calm ? 0 : draw_wait();
            if (stall_left > 0) begin
                out_stall <= 1'b1;
            end
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one item and returns at the edge at which it is taken. When no
    // gap is drawn the valid simply stays high from the previous item.
    task automatic send_item(input logic k, input t_cube cube, input logic [ROUND_BITS-1:0] r);
        int gap;
        gap = sender_calm ? 0 : draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        cube_in     <= cube;
        round_index <= r;
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    // Drops the valid and waits until every predicted cube has been seen.
    // The opening wait lets the checker book the last item offered; the
    // DRAIN_CYCLES tail covers the pipeline with room to spare.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_count != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The register may only change while nothing is in flight.
    task automatic write_drop_self(input logic value);
        wait_until_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Directed items: the extreme cubes and round numbers, all three axis
    // pairs, equal line numbers (round numbers 0 or 1 mod 16), a square that
    // wraps far beyond four bits, and unused fields carrying junk that must be
    // ignored.
    task automatic run_directed();
        send_item(KIND_LOAD,  '1,                    16'h0000);
        send_item(KIND_ROUND, '0,                    16'h0000);
        send_item(KIND_ROUND, '1,                    16'h0001);
        send_item(KIND_ROUND, '0,                    16'h0002);
        send_item(KIND_LOAD,  64'h0000_0000_0000_0001, 16'hFFFF);
        send_item(KIND_ROUND, '0,                    16'hFFFF);
        send_item(KIND_ROUND, '1,                    16'h8000);
        send_item(KIND_LOAD,  64'h8000_0000_0000_0000, 16'h0000);
        send_item(KIND_ROUND, '0,                    16'h0011);
        send_item(KIND_LOAD,  64'hA5A5_5A5A_F00F_0FF0, 16'h5555);
        send_item(KIND_ROUND, '0,                    16'h000E);
        send_item(KIND_ROUND, '1,                    16'h0007);
    endtask

    // Random items. Rounds dominate so that the cube evolves over long runs;
    // loads now and then reseed it with dense, sparse or extreme patterns.
    task automatic send_random_item();
        t_cube                 cube;
        logic [ROUND_BITS-1:0] r;
        int                    pick;
        cube = {$urandom, $urandom};
        r    = ROUND_BITS'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: cube = '0;
                1: cube = t_cube'(64'd1) << $urandom_range(0, CUBE_BITS - 1);
                2: cube = '1;
                default: cube = cube & {$urandom, $urandom};
            endcase
            send_item(KIND_LOAD, cube, r);
        end else begin
            case ($urandom_range(0, 7))
                // Equal line numbers, so every swap is skipped.
                0: r[3:0] = 4'($urandom_range(0, 1));
                1: r = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: ;
            endcase
            send_item(KIND_ROUND, cube, r);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The directed list runs once at the reset setting and once with the
        // cell's own value left out.
        run_directed();
        write_drop_self(1'b1);
        run_directed();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_drop_self(phase[0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 60 == 0) begin
                    sender_calm = ($urandom_range(0, 3) == 0);
                end
                send_random_item();
            end
        end

        wait_until_idle();
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
